FILE: hdl/tapc_pkg.sv
// tapc_pkg: shared constants and selection tables for the triangle area and
// point containment pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tapc_pkg;

   localparam int COORD_BITS_DEF   = 12;
   localparam int ROOT_FRAC_DEF    = 8;
   localparam int RAD_W            = 64;   // radicand width, wraps modulo 2^64
   localparam int AREA_W           = 27;
   localparam int TOL_W            = 8;
   localparam logic [TOL_W-1:0] TOL_RESET = 8'd4;
   localparam int NUM_FIELDS       = 12;
   localparam int NUM_PAIRS        = 6;
   localparam int NUM_TRIS         = 4;
   localparam int RSP_DATA_W       = 32;

   // vertex pairs: ab, ac, bc, ap, bp, cp (vertex 3 is the test point)
   localparam int PAIR_U [NUM_PAIRS] = '{0, 0, 1, 0, 1, 2};
   localparam int PAIR_V [NUM_PAIRS] = '{1, 2, 2, 3, 3, 3};

   // triangles abc, abp, acp, bcp as (l1, l2, l3) pair picks
   localparam int TRI_L1 [NUM_TRIS] = '{0, 0, 1, 2};
   localparam int TRI_L2 [NUM_TRIS] = '{1, 3, 3, 4};
   localparam int TRI_L3 [NUM_TRIS] = '{2, 4, 5, 5};

endpackage
`default_nettype wire

FILE: hdl/triangle_area_point_containment.sv
// triangle_area_point_containment: heron area of a 3d triangle and a
// point containment test by sub-area sum. Depends on tapc_pkg.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   direction  ports                         transfer carries
//  req       in         req_tvalid/tready/tdata       vertices a, b, c and test point
//  rsp       out        rsp_tvalid/tready/tdata       area_quarters, inside_res
//  csr       in         csr_valid/ready/data          match_tolerance
//
//  one item enters every cycle unless the pipeline holds, set by the bit-per-stage
//  square root chain (32 + ROOT_FRACTION_BITS stages, four roots side by side)
//  synchronous reset clears all valid bits and sets match_tolerance to 4
//  the whole pipeline holds when a result waits and rsp_tready is low
//  csr is always ready; write it only while the pipeline is empty
//
module triangle_area_point_containment #(
   parameter int COORD_BITS         = tapc_pkg::COORD_BITS_DEF,
   parameter int ROOT_FRACTION_BITS = tapc_pkg::ROOT_FRAC_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // a_x a_y a_z b_x b_y b_z c_x c_y c_z point_x point_y point_z, zero pad
   input  wire logic [((tapc_pkg::NUM_FIELDS*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // area_quarters [26:0], inside_res [27], zero pad
   output logic [tapc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [tapc_pkg::TOL_W-1:0] csr_data
);

   localparam int DW     = COORD_BITS + 1;         // coordinate difference
   localparam int SQ_W   = 2 * DW;
   localparam int L_W    = SQ_W + 2;               // squared side length
   localparam int T_W    = L_W + 2;                // l1 + l2 - l3, signed
   localparam int P_W    = 2 * L_W;
   localparam int TT_W   = 2 * T_W;
   localparam int ROOT_W = 32 + ROOT_FRACTION_BITS;
   localparam int REM_W  = ROOT_W + 2;
   localparam int SUM_W  = ROOT_W + 2;
   localparam int RW     = tapc_pkg::RAD_W;

   // one enable for every stage: move when the output slot is free or taken
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // tolerance register
   logic [tapc_pkg::TOL_W-1:0] tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tapc_pkg::TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // unpack vertices
   logic signed [COORD_BITS-1:0] pt [4][3];
   always_comb begin
      for (int v = 0; v < 4; v++) begin
         for (int k = 0; k < 3; k++) begin
            pt[v][k] = $signed(req_tdata[(v*3+k)*COORD_BITS +: COORD_BITS]);
         end
      end
   end

   // stage 1: coordinate differences of the six vertex pairs
   logic signed [DW-1:0] dif_ff [tapc_pkg::NUM_PAIRS][3];
   logic                 dif_vld_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int p = 0; p < tapc_pkg::NUM_PAIRS; p++) begin
            for (int k = 0; k < 3; k++) begin
               dif_ff[p][k] <= DW'(pt[tapc_pkg::PAIR_U[p]][k])
                             - DW'(pt[tapc_pkg::PAIR_V[p]][k]);
            end
         end
      end
   end

   // stage 2: squared side lengths, each square at full width
   logic [L_W-1:0] len_ff [tapc_pkg::NUM_PAIRS];
   logic           len_vld_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int p = 0; p < tapc_pkg::NUM_PAIRS; p++) begin
            len_ff[p] <= L_W'($unsigned(SQ_W'(dif_ff[p][0]) * SQ_W'(dif_ff[p][0])))
                       + L_W'($unsigned(SQ_W'(dif_ff[p][1]) * SQ_W'(dif_ff[p][1])))
                       + L_W'($unsigned(SQ_W'(dif_ff[p][2]) * SQ_W'(dif_ff[p][2])));
         end
      end
   end

   // stage 3: l1*l2 and t = l1 + l2 - l3 per triangle
   logic [P_W-1:0]        prd_ff [tapc_pkg::NUM_TRIS];
   logic signed [T_W-1:0] t_ff   [tapc_pkg::NUM_TRIS];
   logic                  prd_vld_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < tapc_pkg::NUM_TRIS; i++) begin
            prd_ff[i] <= len_ff[tapc_pkg::TRI_L1[i]] * len_ff[tapc_pkg::TRI_L2[i]];
            t_ff[i]   <= $signed({2'b00, len_ff[tapc_pkg::TRI_L1[i]]})
                       + $signed({2'b00, len_ff[tapc_pkg::TRI_L2[i]]})
                       - $signed({2'b00, len_ff[tapc_pkg::TRI_L3[i]]});
         end
      end
   end

   // stage 4: t squared, 4*l1*l2 carried along
   logic [P_W+1:0]         four_ff [tapc_pkg::NUM_TRIS];
   logic signed [TT_W-1:0] tt_ff   [tapc_pkg::NUM_TRIS];
   logic                   tt_vld_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < tapc_pkg::NUM_TRIS; i++) begin
            four_ff[i] <= {prd_ff[i], 2'b00};
            tt_ff[i]   <= t_ff[i] * t_ff[i];
         end
      end
   end

   // root chain, index 0 is the radicand stage (16*area^2 modulo 2^64)
   logic [RW-1:0]     rad_ff  [ROOT_W+1][tapc_pkg::NUM_TRIS];
   logic [REM_W-1:0]  rem_ff  [ROOT_W+1][tapc_pkg::NUM_TRIS];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1][tapc_pkg::NUM_TRIS];
   logic [ROOT_W:0]   rt_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < tapc_pkg::NUM_TRIS; i++) begin
            rad_ff[0][i]  <= RW'(four_ff[i]) - RW'(tt_ff[i]);
            rem_ff[0][i]  <= '0;
            root_ff[0][i] <= '0;
         end
      end
   end

   // one result bit per stage: shift in the next radicand pair, try to subtract
   for (genvar s = 0; s < ROOT_W; s++) begin : g_root
      for (genvar i = 0; i < tapc_pkg::NUM_TRIS; i++) begin : g_tri
         logic [REM_W-1:0] rem_sh, trial;
         logic             ge;
         assign rem_sh = {rem_ff[s][i][REM_W-3:0], rad_ff[s][i][RW-1 -: 2]};
         assign trial  = {root_ff[s][i], 2'b01};
         assign ge     = rem_sh >= trial;
         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[s+1][i]  <= {rad_ff[s][i][RW-3:0], 2'b00};
               rem_ff[s+1][i]  <= ge ? rem_sh - trial : rem_sh;
               root_ff[s+1][i] <= {root_ff[s][i][ROOT_W-2:0], ge};
            end
         end
      end
   end

   // sum of the three sub-areas
   logic [SUM_W-1:0]  sum_ff;
   logic [ROOT_W-1:0] tot_ff;
   logic              sum_vld_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         tot_ff <= root_ff[ROOT_W][0];
         sum_ff <= SUM_W'(root_ff[ROOT_W][1]) + SUM_W'(root_ff[ROOT_W][2])
                 + SUM_W'(root_ff[ROOT_W][3]);
      end
   end

   // output register: absolute difference against tolerance
   logic [SUM_W-1:0]           diff;
   logic [tapc_pkg::AREA_W-1:0] area_ff;
   logic                       inside_ff;
   logic                       out_vld_ff;
   assign diff = (sum_ff > SUM_W'(tot_ff)) ? sum_ff - SUM_W'(tot_ff)
                                           : SUM_W'(tot_ff) - sum_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         area_ff   <= tot_ff[ROOT_FRACTION_BITS +: tapc_pkg::AREA_W];
         inside_ff <= diff <= SUM_W'(tol_ff);
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         dif_vld_ff <= 1'b0;
         len_vld_ff <= 1'b0;
         prd_vld_ff <= 1'b0;
         tt_vld_ff  <= 1'b0;
         rt_vld_ff  <= '0;
         sum_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         dif_vld_ff <= req_tvalid;
         len_vld_ff <= dif_vld_ff;
         prd_vld_ff <= len_vld_ff;
         tt_vld_ff  <= prd_vld_ff;
         rt_vld_ff  <= {rt_vld_ff[ROOT_W-1:0], tt_vld_ff};
         sum_vld_ff <= rt_vld_ff[ROOT_W];
         out_vld_ff <= sum_vld_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(tapc_pkg::RSP_DATA_W-tapc_pkg::AREA_W-1){1'b0}},
                        inside_ff, area_ff};

endmodule
`default_nettype wire
